// ----- hdl/rvia_pkg.sv -----
// ----------------------------------------------------------------------------
// rvia_pkg
// Shared types and constants for the RV64 immediate ALU execute block.
// ----------------------------------------------------------------------------
package rvia_pkg;

  localparam int unsigned Xlen       = 64;
  localparam int unsigned InstrW     = 32;
  localparam int unsigned RegAddrW   = 5;
  localparam int unsigned RegCntW    = RegAddrW + 1;
  localparam int unsigned NumRegsDef = 32;

  // Major opcodes handled by this unit
  localparam logic [6:0] OpcOpImm = 7'h13;
  localparam logic [6:0] OpcLui   = 7'h37;
  localparam logic [6:0] OpcAuipc = 7'h17;

  // OP-IMM function codes
  localparam logic [2:0] F3Addi  = 3'd0;
  localparam logic [2:0] F3Slli  = 3'd1;
  localparam logic [2:0] F3Slti  = 3'd2;
  localparam logic [2:0] F3Sltiu = 3'd3;
  localparam logic [2:0] F3Xori  = 3'd4;
  localparam logic [2:0] F3Sri   = 3'd5;
  localparam logic [2:0] F3Ori   = 3'd6;
  localparam logic [2:0] F3Andi  = 3'd7;

  // Upper six bits of a shift instruction
  localparam logic [5:0] F6Logic = 6'h00;
  localparam logic [5:0] F6Arith = 6'h10;

  typedef struct packed {
    logic [InstrW-1:0] instruction_word;
    logic [Xlen-1:0]   pc_value;
  } in_t;

  typedef struct packed {
    logic [RegAddrW-1:0] dest_index;
    logic [Xlen-1:0]     write_value;
    logic                wrote;
    logic                illegal;
  } out_t;

  // Register file write port
  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [Xlen-1:0]     data;
  } wr_t;

endpackage

// ----- hdl/rvia_regfile.sv -----
// ----------------------------------------------------------------------------
// rvia_regfile
// Synchronous register file memory, one read and one write port, read data
// registered. Per-entry valid bits make unwritten entries read as zero, and a
// write landing on the edge of a read to the same entry is forwarded.
// ----------------------------------------------------------------------------
module rvia_regfile
  import rvia_pkg::*;
#(
  parameter int unsigned NumRegs = NumRegsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [RegAddrW-1:0] rd_addr_i,
  input  wr_t                 wr_i,
  output logic [Xlen-1:0]     rd_data_o
);

  localparam int unsigned IdxW = (NumRegs > 1) ? $clog2(NumRegs) : 1;

  logic [Xlen-1:0]    mem_q [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic [Xlen-1:0]    rdata_q;
  logic               rvld_q;
  logic               fwd_hit_q;
  logic [Xlen-1:0]    fwd_data_q;
  logic               rd_in_range;
  logic [IdxW-1:0]    rd_idx;
  logic [IdxW-1:0]    wr_idx;

  assign rd_in_range = ({1'b0, rd_addr_i} < RegCntW'(NumRegs));
  assign rd_idx      = rd_addr_i[IdxW-1:0];
  assign wr_idx      = wr_i.addr[IdxW-1:0];

  // Write and read the storage array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx] <= wr_i.data;
    end
    if (rd_en_i && rd_in_range) begin
      rdata_q <= mem_q[rd_idx];
    end
  end

  // Track written entries and capture same-edge write forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rvld_q     <= 1'b0;
      fwd_hit_q  <= 1'b0;
      fwd_data_q <= '0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q     <= rd_in_range && vld_q[rd_idx];
        fwd_hit_q  <= wr_i.en && (wr_i.addr == rd_addr_i);
        fwd_data_q <= wr_i.data;
      end
    end
  end

  // Pick forwarded, stored or reset value
  always_comb begin
    if (fwd_hit_q) begin
      rd_data_o = fwd_data_q;
    end else if (rvld_q) begin
      rd_data_o = rdata_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

// ----- hdl/rvia_alu.sv -----
// ----------------------------------------------------------------------------
// rvia_alu
// Decodes the I-type and U-type fields and computes the result of one
// immediate ALU instruction, along with legality and write enable.
// ----------------------------------------------------------------------------
module rvia_alu
  import rvia_pkg::*;
#(
  parameter int unsigned NumRegs = NumRegsDef
) (
  input  in_t             instr_i,
  input  logic [Xlen-1:0] rs1_data_i,
  output out_t            res_o
);

  logic [6:0]          opcode;
  logic [RegAddrW-1:0] rd;
  logic [RegAddrW-1:0] rs1;
  logic [2:0]          funct3;
  logic [5:0]          funct6;
  logic [5:0]          shamt;
  logic [Xlen-1:0]     imm_i;
  logic [Xlen-1:0]     imm_u;
  logic [Xlen-1:0]     a;
  logic [Xlen-1:0]     value;
  logic                legal;
  logic                rd_ok;
  logic                rs1_ok;

  assign opcode = instr_i.instruction_word[6:0];
  assign rd     = instr_i.instruction_word[11:7];
  assign funct3 = instr_i.instruction_word[14:12];
  assign rs1    = instr_i.instruction_word[19:15];
  assign shamt  = instr_i.instruction_word[25:20];
  assign funct6 = instr_i.instruction_word[31:26];
  assign imm_i  = {{(Xlen-12){instr_i.instruction_word[31]}},
                   instr_i.instruction_word[31:20]};
  assign imm_u  = {{(Xlen-32){instr_i.instruction_word[31]}},
                   instr_i.instruction_word[31:12], 12'b0};
  assign a      = rs1_data_i;
  assign rd_ok  = ({1'b0, rd} < RegCntW'(NumRegs));
  assign rs1_ok = ({1'b0, rs1} < RegCntW'(NumRegs));

  // Execute the decoded operation
  always_comb begin
    value = '0;
    legal = 1'b0;
    case (opcode)
      OpcLui: begin
        value = imm_u;
        legal = 1'b1;
      end
      OpcAuipc: begin
        value = instr_i.pc_value + imm_u;
        legal = 1'b1;
      end
      OpcOpImm: begin
        legal = rs1_ok;
        case (funct3)
          F3Addi:  value = a + imm_i;
          F3Slti:  value = Xlen'($signed(a) < $signed(imm_i));
          F3Sltiu: value = Xlen'(a < imm_i);
          F3Xori:  value = a ^ imm_i;
          F3Ori:   value = a | imm_i;
          F3Andi:  value = a & imm_i;
          F3Slli: begin
            value = a << shamt;
            if (funct6 != F6Logic) legal = 1'b0;
          end
          F3Sri: begin
            if (funct6 == F6Logic) begin
              value = a >> shamt;
            end else if (funct6 == F6Arith) begin
              value = $signed(a) >>> shamt;
            end else begin
              legal = 1'b0;
            end
          end
          default: legal = 1'b0;
        endcase
      end
      default: legal = 1'b0;
    endcase
  end

  // Drop the write for illegal words and for x0
  always_comb begin
    res_o.dest_index  = rd;
    res_o.illegal     = !(legal && rd_ok);
    res_o.wrote       = legal && rd_ok && (rd != '0);
    res_o.write_value = res_o.wrote ? value : '0;
  end

endmodule

// ----- hdl/rv64_immediate_alu_execute.sv -----
// ----------------------------------------------------------------------------
// rv64_immediate_alu_execute
// RV64I immediate ALU execute stage with an internal register file.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) takes one word:
//   a 32-bit instruction and its pc. The output channel (out_valid_o /
//   out_stall_i / out_data_o) returns one word per input: destination index,
//   written value, write flag and illegal flag.
//   Throughput is one word per cycle while the output is not stalled.
//   The edge that accepts a word issues the register file read and loads
//   the execute stage; as it advances it writes back and loads the output register.
//   The register file is a synchronous memory with registered read data;
//   a write-back on the same edge as the next word's read is forwarded, so
//   dependent words follow back to back.
//   After reset every register reads zero (per-entry valid bits, no clearing
//   pass) and both channels are empty.
//   When the receiver stalls, the output word holds; the execute stage still
//   fills once, and then in_stall_o rises until the output drains.
// ----------------------------------------------------------------------------
module rv64_immediate_alu_execute
  import rvia_pkg::*;
#(
  parameter int unsigned NumRegs = NumRegsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic            s1_valid_q;
  in_t             s1_data_q;
  logic            out_valid_q;
  out_t            out_data_q;
  logic            out_free;
  logic            s1_advance;
  logic            in_accept;
  logic [Xlen-1:0] rs1_data;
  out_t            alu_res;
  wr_t             wr;

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  rvia_regfile #(
    .NumRegs(NumRegs)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_accept),
    .rd_addr_i(in_data_i.instruction_word[19:15]),
    .wr_i     (wr),
    .rd_data_o(rs1_data)
  );

  rvia_alu #(
    .NumRegs(NumRegs)
  ) u_alu (
    .instr_i   (s1_data_q),
    .rs1_data_i(rs1_data),
    .res_o     (alu_res)
  );

  // Write back when the execute stage advances
  always_comb begin
    wr.en   = s1_advance && alu_res.wrote;
    wr.addr = alu_res.dest_index;
    wr.data = alu_res.write_value;
  end

  // Advance the execute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_data_q <= alu_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
